@@ rtl/core/lemc_pkg.sv @@
// Shared types and constants of the line exact match counter.
`default_nettype none

package lemc_pkg;

    localparam int IDX_W   = 3;
    localparam int BPOS_W  = 7;
    localparam int LEN_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 32;
    localparam int OUT_PATTERNS = 6;

    // item kinds on the feed channel
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [POS_W-1:0]   POS_MAX      = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TEXT,
        OP_EOL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  index;
        logic [BPOS_W-1:0] bpos;
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/lemc_in_if.sv @@
// Input channel: pattern load and text byte items.
`default_nettype none

interface lemc_in_if;
    logic       valid;
    logic       ready;
    logic [0:0] kind;
    logic [2:0] pattern_index;
    logic [6:0] byte_position;
    logic [6:0] pattern_length;
    logic [7:0] char_value;

    modport source (
        output valid, kind, pattern_index, byte_position, pattern_length, char_value,
        input  ready
    );
    modport sink (
        input  valid, kind, pattern_index, byte_position, pattern_length, char_value,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/lemc_out_if.sv @@
// Output channel: match mask and counts for each ended line.
`default_nettype none

interface lemc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  match_mask;
    logic [31:0] count_zero;
    logic [31:0] count_one;
    logic [31:0] count_two;
    logic [31:0] count_three;
    logic [31:0] count_four;
    logic [31:0] count_five;

    modport source (
        output valid, match_mask, count_zero, count_one, count_two,
               count_three, count_four, count_five,
        input  ready
    );
    modport sink (
        input  valid, match_mask, count_zero, count_one, count_two,
               count_three, count_four, count_five,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/line_exact_match_counter.sv @@
// Top level of the line exact match counter.
// Path: a newline item passes the queue, the compare stage register and the result register.
// Throughput: one item per cycle; the back end stalls only while a line result
// waits in a full output register, and the four-entry queue absorbs that until it fills.
// Reset: position, mismatch flags, lengths and counts clear at once; pattern
// bytes stay undefined until loaded, with no clearing pass.
`default_nettype none

module line_exact_match_counter #(
    parameter int NUM_PATTERNS    = 6,
    parameter int MAX_PATTERN_LEN = 128
) (
    input  wire         clk,
    input  wire         rst_n,
    lemc_in_if.sink     feed,
    lemc_out_if.source  result
);

    // front end -> queue
    logic           push;
    lemc_pkg::cmd_t push_cmd;
    logic           q_full;

    // queue -> back end
    logic           q_pop;
    lemc_pkg::cmd_t q_cmd;
    logic           q_empty;

    // Front end: classifies each item as a load, a text byte or an end of
    // line, clamps the length and drops loads to patterns that do not exist.
    lemc_front #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_front (
        .feed     (feed),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue decouples input acceptance from back-end stalls.
    lemc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .empty    (q_empty)
    );

    // Back end: issue stage reads every pattern bank at the line position;
    // the compare stage folds mismatches into the flags, or on a newline
    // forms the mask, bumps the saturating counts and loads the result.
    // Loads write in issue order, so a later text byte sees the new pattern.
    lemc_back #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ rtl/core/lemc_front.sv @@
// Front end: accepts items, classifies them and drops ignored loads.
`default_nettype none

module lemc_front #(
    parameter int NUM_PATTERNS    = 6,
    parameter int MAX_PATTERN_LEN = 128
) (
    lemc_in_if.sink        feed,
    input  wire            q_full,
    output logic           push,
    output lemc_pkg::cmd_t push_cmd
);

    logic keep;

    assign feed.ready = !q_full;

    always_comb
    begin
        push_cmd.index = feed.pattern_index;
        push_cmd.bpos  = feed.byte_position;
        push_cmd.ch    = feed.char_value;
        // stored length is clamped to the pattern capacity
        if (32'(feed.pattern_length) > MAX_PATTERN_LEN)
        begin
            push_cmd.len = lemc_pkg::LEN_W'(MAX_PATTERN_LEN);
        end
        else
        begin
            push_cmd.len = feed.pattern_length;
        end

        if (feed.kind == lemc_pkg::KIND_LOAD)
        begin
            push_cmd.op = lemc_pkg::OP_LOAD;
        end
        else if (feed.char_value == lemc_pkg::NEWLINE_CHAR)
        begin
            push_cmd.op = lemc_pkg::OP_EOL;
        end
        else
        begin
            push_cmd.op = lemc_pkg::OP_TEXT;
        end

        // loads to a pattern that does not exist are swallowed here
        keep = (feed.kind == lemc_pkg::KIND_TEXT)
               || (32'(feed.pattern_index) < NUM_PATTERNS);
    end

    assign push = feed.valid && feed.ready && keep;

endmodule

`default_nettype wire

@@ rtl/core/lemc_queue.sv @@
// Short command queue between front and back end.
`default_nettype none

module lemc_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  lemc_pkg::cmd_t push_cmd,
    output logic           full,
    input  wire            pop,
    output lemc_pkg::cmd_t pop_cmd,
    output logic           empty
);

    lemc_pkg::cmd_t                      entry_reg [lemc_pkg::QUEUE_DEPTH];
    logic [lemc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lemc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lemc_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;

    assign full    = (count_reg == lemc_pkg::QUEUE_CNT_W'(lemc_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lemc_back.sv @@
// Back end: pattern memories, compare stage, counters and result register.
`default_nettype none

module lemc_back #(
    parameter int NUM_PATTERNS    = 6,
    parameter int MAX_PATTERN_LEN = 128
) (
    input  wire             clk,
    input  wire             rst_n,
    input  lemc_pkg::cmd_t  q_cmd,
    input  wire             q_empty,
    output logic            q_pop,
    lemc_out_if.source      result
);

    localparam int AW = $clog2(MAX_PATTERN_LEN);
    localparam int NP = lemc_pkg::OUT_PATTERNS;

    logic [lemc_pkg::POS_W-1:0]                    line_pos_reg, line_pos_next;
    logic                                          s1_valid_reg;
    lemc_pkg::op_t                                 s1_op_reg;
    logic [lemc_pkg::POS_W-1:0]                    s1_pos_reg;
    logic [lemc_pkg::CHAR_W-1:0]                   s1_ch_reg;
    logic [NUM_PATTERNS-1:0][lemc_pkg::LEN_W-1:0]  len_reg;
    logic [NUM_PATTERNS-1:0]                       flags_reg, flags_next;
    logic [NUM_PATTERNS-1:0][lemc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                                          out_valid_reg, out_valid_next;
    logic [NP-1:0]                                 out_mask_reg, out_mask_next;
    logic [NP-1:0][lemc_pkg::COUNT_W-1:0]          out_count_reg, out_count_next;

    logic [NUM_PATTERNS-1:0][lemc_pkg::CHAR_W-1:0] bank_rd;
    logic [NUM_PATTERNS-1:0]                       miss, hit;
    logic                                          stall, fire, fire_eol;
    logic                                          pop_load, pop_text;
    logic [31:0]                                   bpos32, pos32;
    logic [AW-1:0]                                 wr_addr, rd_addr;
    logic                                          bpos_ok;

    // only a line result waiting on a full output register holds the pipe
    assign stall    = s1_valid_reg && (s1_op_reg == lemc_pkg::OP_EOL)
                      && out_valid_reg && !result.ready;
    assign q_pop    = !q_empty && !stall;
    assign fire     = s1_valid_reg && !stall;
    assign fire_eol = fire && (s1_op_reg == lemc_pkg::OP_EOL);
    assign pop_load = q_pop && (q_cmd.op == lemc_pkg::OP_LOAD);
    assign pop_text = q_pop && (q_cmd.op == lemc_pkg::OP_TEXT);

    assign bpos32  = 32'(q_cmd.bpos);
    assign pos32   = 32'(line_pos_reg);
    assign wr_addr = bpos32[AW-1:0];
    assign rd_addr = pos32[AW-1:0];
    assign bpos_ok = (bpos32 < MAX_PATTERN_LEN);

    // one byte-wide bank per pattern, all read at the line position
    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_bank
        logic [lemc_pkg::CHAR_W-1:0] mem [MAX_PATTERN_LEN];
        logic [lemc_pkg::CHAR_W-1:0] rd_reg;
        logic                        we;

        assign we = pop_load && bpos_ok && (32'(q_cmd.index) == p);

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[wr_addr] <= q_cmd.ch;
            end
            if (pop_text)
            begin
                rd_reg <= mem[rd_addr];
            end
        end

        assign bank_rd[p] = rd_reg;
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            miss[p] = (s1_pos_reg >= {1'b0, len_reg[p]})
                      || (bank_rd[p] != s1_ch_reg);
            hit[p]  = !flags_reg[p] && (s1_pos_reg == {1'b0, len_reg[p]});
            if (fire_eol && hit[p] && (count_reg[p] != lemc_pkg::COUNT_MAX))
            begin
                count_next[p] = count_reg[p] + 1'b1;
            end
            else
            begin
                count_next[p] = count_reg[p];
            end
        end

        flags_next = flags_reg;
        if (fire && (s1_op_reg == lemc_pkg::OP_TEXT))
        begin
            flags_next = flags_reg | miss;
        end
        else if (fire_eol)
        begin
            flags_next = '0;
        end

        line_pos_next = line_pos_reg;
        if (pop_text && (line_pos_reg != lemc_pkg::POS_MAX))
        begin
            line_pos_next = line_pos_reg + 1'b1;
        end
        else if (q_pop && (q_cmd.op == lemc_pkg::OP_EOL))
        begin
            line_pos_next = '0;
        end

        out_valid_next = out_valid_reg;
        if (fire_eol)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // patterns beyond the configured count read as zero on the outputs
    for (genvar i = 0; i < NP; i++)
    begin : g_out
        if (i < NUM_PATTERNS)
        begin : g_live
            assign out_mask_next[i]  = hit[i];
            assign out_count_next[i] = count_next[i];
        end
        else
        begin : g_none
            assign out_mask_next[i]  = 1'b0;
            assign out_count_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= lemc_pkg::OP_LOAD;
            len_reg       <= '0;
            flags_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            line_pos_reg  <= line_pos_next;
            flags_reg     <= flags_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (!stall)
            begin
                s1_valid_reg <= q_pop;
                s1_op_reg    <= q_cmd.op;
            end
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                if (pop_load && (32'(q_cmd.index) == p))
                begin
                    len_reg[p] <= q_cmd.len;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_pos_reg <= line_pos_reg;
            s1_ch_reg  <= q_cmd.ch;
        end
        if (fire_eol)
        begin
            out_mask_reg  <= out_mask_next;
            out_count_reg <= out_count_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_mask  = out_mask_reg;
    assign result.count_zero  = out_count_reg[0];
    assign result.count_one   = out_count_reg[1];
    assign result.count_two   = out_count_reg[2];
    assign result.count_three = out_count_reg[3];
    assign result.count_four  = out_count_reg[4];
    assign result.count_five  = out_count_reg[5];

endmodule

`default_nettype wire

@@ verif/tb_line_exact_match_counter.sv @@
// Self-checking testbench of the line exact match counter.
`default_nettype none

module tb_line_exact_match_counter;
    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration under test; the predictor works at the same sizes.
    localparam int NUM_PAT     = 6;
    localparam int PAT_LEN_MAX = 128;

    // Longest byte position and length the 7-bit fields can carry.
    localparam int FIELD_MAX = 127;

    typedef logic [7:0] char_q_t[$];

    // One line result: mask of matching patterns plus all six counts.
    typedef struct packed {
        logic [5:0]       mask;
        logic [5:0][31:0] counts;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lemc_in_if  feed_ch ();
    lemc_out_if result_ch ();

    line_exact_match_counter #(
        .NUM_PATTERNS    (NUM_PAT),
        .MAX_PATTERN_LEN (PAT_LEN_MAX)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (result_ch)
    );

    // Shadow copy of the pattern memory and the line tracking state.
    logic [7:0]  pat_bytes   [NUM_PAT][PAT_LEN_MAX];
    bit          pat_written [NUM_PAT][PAT_LEN_MAX];
    int          pat_len     [NUM_PAT];
    int          line_pos;
    logic [5:0]  miss_flags;
    logic [31:0] hit_count   [NUM_PAT];

    // Line results still owed by the block, oldest first.
    line_result_t line_results_due[$];

    int mismatches;
    int items_sent;      // accepted items, ignored loads left out
    int src_idle_pct;
    int snk_stall_pct;

    string count_field[6] = '{"count_zero", "count_one", "count_two",
                              "count_three", "count_four", "count_five"};

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop, well beyond the slowest legitimate run.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random back-pressure at the rate of the current phase.
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    // ------------------------------------------------------------------
    // Predictor: advance the shadow state by one accepted item and queue
    // the result a newline gives.
    // ------------------------------------------------------------------
    function automatic void track_item(input logic kind, input logic [2:0] idx,
                                       input logic [6:0] bpos, input logic [6:0] len,
                                       input logic [7:0] ch);
        line_result_t r;
        if (kind == lemc_pkg::KIND_LOAD)
        begin
            // loads beyond the last pattern are dropped whole
            if (idx < NUM_PAT)
            begin
                if (bpos < PAT_LEN_MAX)
                begin
                    pat_bytes[idx][bpos]   = ch;
                    pat_written[idx][bpos] = 1'b1;
                end
                pat_len[idx] = (len > PAT_LEN_MAX) ? PAT_LEN_MAX : int'(len);
            end
        end
        else if (ch != lemc_pkg::NEWLINE_CHAR)
        begin
            // a byte past the length, or a differing byte, rules the pattern out
            for (int p = 0; p < NUM_PAT; p++)
            begin
                if (line_pos >= pat_len[p] || line_pos >= PAT_LEN_MAX)
                    miss_flags[p] = 1'b1;
                else if (pat_bytes[p][line_pos] != ch)
                    miss_flags[p] = 1'b1;
            end
            if (line_pos < lemc_pkg::POS_MAX)
                line_pos++;
        end
        else
        begin
            r = '0;
            for (int p = 0; p < NUM_PAT; p++)
            begin
                if (!miss_flags[p] && line_pos == pat_len[p])
                begin
                    r.mask[p] = 1'b1;
                    if (hit_count[p] != lemc_pkg::COUNT_MAX)
                        hit_count[p]++;
                end
            end
            for (int p = 0; p < 6; p++)
                r.counts[p] = (p < NUM_PAT) ? hit_count[p] : '0;
            line_results_due.push_back(r);
            line_pos   = 0;
            miss_flags = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest one due.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        line_result_t     want;
        logic [5:0][31:0] got_counts;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got_counts = {result_ch.count_five, result_ch.count_four, result_ch.count_three,
                          result_ch.count_two, result_ch.count_one, result_ch.count_zero};
            if (line_results_due.size() == 0)
            begin
                $error("unexpected line result: match_mask %0h", result_ch.match_mask);
                mismatches++;
            end
            else
            begin
                want = line_results_due.pop_front();
                if (result_ch.match_mask !== want.mask)
                begin
                    $error("match_mask: expected %0h, got %0h", want.mask, result_ch.match_mask);
                    mismatches++;
                end
                for (int p = 0; p < 6; p++)
                begin
                    if (got_counts[p] !== want.counts[p])
                    begin
                        $error("%s: expected %0d, got %0d", count_field[p],
                               want.counts[p], got_counts[p]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drive one item, holding it until accepted; random idle cycles first.
    task automatic send_item(input logic kind, input logic [2:0] idx, input logic [6:0] bpos,
                             input logic [6:0] len, input logic [7:0] ch);
        while ($urandom_range(99) < src_idle_pct)
        begin
            feed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        feed_ch.valid          <= 1'b1;
        feed_ch.kind           <= kind;
        feed_ch.pattern_index  <= idx;
        feed_ch.byte_position  <= bpos;
        feed_ch.pattern_length <= len;
        feed_ch.char_value     <= ch;
        @(posedge clk);
        while (feed_ch.ready !== 1'b1)
            @(posedge clk);
        track_item(kind, idx, bpos, len, ch);
        if (!(kind == lemc_pkg::KIND_LOAD && idx >= NUM_PAT))
            items_sent++;
    endtask

    // Text item; the load-only fields carry noise.
    task automatic send_text(input logic [7:0] ch);
        send_item(lemc_pkg::KIND_TEXT, 3'($urandom_range(7)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), ch);
    endtask

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == lemc_pkg::NEWLINE_CHAR);
        return c;
    endfunction

    // Length of the unbroken written run from byte 0, counting one pending write.
    // Lengths never exceed it, so no unwritten pattern byte is ever compared.
    function automatic int written_prefix(input int p, input int extra);
        int n = 0;
        while (n < PAT_LEN_MAX && (pat_written[p][n] || n == extra))
            n++;
        return (n > FIELD_MAX) ? FIELD_MAX : n;
    endfunction

    // Text bytes followed by a newline; optionally a stray load now and then mid-line.
    task automatic send_line(input char_q_t body, input bit mid_loads);
        foreach (body[i])
        begin
            if (mid_loads && $urandom_range(99) < 3)
                random_load();
            send_text(body[i]);
        end
        send_text(lemc_pkg::NEWLINE_CHAR);
    endtask

    // Write a whole pattern front to back, the length growing with each byte.
    task automatic program_pattern(input int p, input char_q_t body);
        if (body.size() == 0)
            send_item(lemc_pkg::KIND_LOAD, 3'(p), 7'($urandom_range(127)), 7'd0,
                      8'($urandom_range(255)));
        foreach (body[i])
            send_item(lemc_pkg::KIND_LOAD, 3'(p), 7'(i), 7'(i + 1), body[i]);
    endtask

    // One legal load: any byte, any length the written run allows.
    task automatic random_load();
        int         p;
        int         bpos;
        int         room;
        logic [7:0] ch;
        p    = $urandom_range(NUM_PAT - 1);
        bpos = $urandom_range(1) ? $urandom_range(127)
                                 : $urandom_range((pat_len[p] < FIELD_MAX) ? pat_len[p] : FIELD_MAX);
        ch   = 8'($urandom_range(255));
        room = written_prefix(p, bpos);
        send_item(lemc_pkg::KIND_LOAD, 3'(p), 7'(bpos), 7'($urandom_range(room)), ch);
    endtask

    // Load aimed at a pattern slot that does not exist.
    task automatic ignored_load();
        send_item(lemc_pkg::KIND_LOAD, 3'($urandom_range(7, NUM_PAT)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), 8'($urandom_range(255)));
    endtask

    // New content for one pattern; short mostly, sometimes long, sometimes
    // sharing a prefix with another pattern so several can match one line.
    task automatic reprogram_pattern();
        char_q_t body;
        int      p;
        int      src;
        int      n;
        p   = $urandom_range(NUM_PAT - 1);
        src = $urandom_range(NUM_PAT - 1);
        n   = ($urandom_range(9) == 0) ? $urandom_range(FIELD_MAX) : $urandom_range(10);
        if ($urandom_range(9) < 3)
        begin
            for (int i = 0; i < n; i++)
                body.push_back((i < pat_len[src]) ? pat_bytes[src][i] : rand_char());
        end
        else
        begin
            for (int i = 0; i < n; i++)
                body.push_back(rand_char());
        end
        program_pattern(p, body);
    endtask

    // A line built around a stored pattern: exact, cut short, run on, one
    // bit flipped, or unrelated bytes.
    task automatic send_random_line();
        char_q_t body;
        int      t;
        int      k;
        int      variant;
        t       = $urandom_range(NUM_PAT - 1);
        variant = $urandom_range(9);
        for (int i = 0; i < pat_len[t]; i++)
            body.push_back(pat_bytes[t][i]);
        if (variant == 5 && body.size() > 0)
            void'(body.pop_back());
        else if (variant == 6)
            body.push_back(rand_char());
        else if (variant == 7 && body.size() > 0)
        begin
            k       = $urandom_range(body.size() - 1);
            body[k] = body[k] ^ (8'd1 << $urandom_range(7));
        end
        else if (variant >= 8)
        begin
            body.delete();
            for (int i = $urandom_range(6); i > 0; i--)
                body.push_back(8'($urandom_range(255)));
        end
        send_line(body, 1'b1);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset every length is zero: an empty line matches all six,
    // any byte in the line matches none.
    task automatic test_empty_patterns();
        char_q_t body;
        send_line(body, 1'b0);
        body.push_back(8'h41);
        send_line(body, 1'b0);
    endtask

    // Field extremes, loads to missing pattern slots, byte position 127.
    task automatic test_field_extremes();
        char_q_t body;
        body.push_back(8'h00);
        body.push_back(8'hFF);
        program_pattern(0, body);
        send_item(lemc_pkg::KIND_LOAD, 3'd3, 7'd127, 7'd0, 8'hAA);
        send_item(lemc_pkg::KIND_LOAD, 3'd6, 7'd127, 7'd127, 8'hFF);
        send_item(lemc_pkg::KIND_LOAD, 3'd7, 7'd0, 7'd0, 8'h00);
        body.delete();
        body.push_back(8'h41);
        program_pattern(5, body);
        body.delete();
        body.push_back(8'h00);
        body.push_back(8'hFF);
        send_line(body, 1'b0);                // pattern 0 only
        body.delete();
        send_line(body, 1'b0);                // the empty patterns
        body.push_back(8'h41);
        send_line(body, 1'b0);                // pattern 5
        body.delete();
        body.push_back(8'h00);
        send_line(body, 1'b0);                // prefix of pattern 0: nothing
    endtask

    // Loads in the middle of a line: a clean pattern may change under the
    // line and still match; a mismatch already flagged stays.
    task automatic test_load_mid_line();
        send_text(8'h41);
        send_item(lemc_pkg::KIND_LOAD, 3'd5, 7'd0, 7'd1, 8'h42);
        send_text(lemc_pkg::NEWLINE_CHAR);
        send_text(8'h41);
        send_item(lemc_pkg::KIND_LOAD, 3'd5, 7'd0, 7'd1, 8'h41);
        send_text(lemc_pkg::NEWLINE_CHAR);
    endtask

    // Line longer than the position counter: it saturates and nothing matches.
    task automatic test_long_line();
        logic [7:0] ch;
        for (int i = 0; i < 260; i++)
        begin
            ch = 8'(i);
            send_text((ch == lemc_pkg::NEWLINE_CHAR) ? 8'hFF : ch);
        end
        send_text(lemc_pkg::NEWLINE_CHAR);
    endtask

    // Longest pattern the length field can carry, hit and then missed on its last byte.
    task automatic test_full_length();
        char_q_t body;
        for (int i = 0; i < FIELD_MAX; i++)
            body.push_back(rand_char());
        program_pattern(1, body);
        send_line(body, 1'b0);
        body[FIELD_MAX - 1] = (body[FIELD_MAX - 1] == 8'h20) ? 8'h21 : 8'h20;
        send_line(body, 1'b0);
    endtask

    task automatic test_random_traffic(input int goal);
        int stop_at;
        int r;
        stop_at = items_sent + goal;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 10)
                reprogram_pattern();
            else if (r < 16)
                random_load();
            else if (r < 20)
                ignored_load();
            else
                send_random_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        feed_ch.valid          = 1'b0;
        feed_ch.kind           = lemc_pkg::KIND_LOAD;
        feed_ch.pattern_index  = '0;
        feed_ch.byte_position  = '0;
        feed_ch.pattern_length = '0;
        feed_ch.char_value     = '0;
        result_ch.ready        = 1'b0;
        mismatches             = 0;
        items_sent             = 0;
        line_pos               = 0;
        miss_flags             = '0;
        set_idling(0, 0);
        for (int p = 0; p < NUM_PAT; p++)
        begin
            pat_len[p]   = 0;
            hit_count[p] = '0;
            for (int b = 0; b < PAT_LEN_MAX; b++)
            begin
                pat_bytes[p][b]   = '0;
                pat_written[p][b] = 1'b0;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_patterns();
        test_field_extremes();
        test_load_mid_line();
        test_long_line();
        test_full_length();

        // random traffic under each idling pattern in turn
        set_idling(0, 0);
        test_random_traffic(35);
        set_idling(82, 0);
        test_random_traffic(35);
        set_idling(0, 82);
        test_random_traffic(35);
        set_idling(18, 18);
        test_random_traffic(35);

        feed_ch.valid <= 1'b0;
        while (line_results_due.size() != 0)
            @(posedge clk);
        // room for any stray result after the last one due
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
